// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file fskc_checker.sv.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fskc_pkg.sv -----
package fskc_pkg;

    localparam int SINE_BITS    = 10;
    localparam int QUARTER_BITS = SINE_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 15;
    localparam int GAIN_W       = 15;
    localparam int STEP_W       = 32;
    localparam int SLOPE_W      = 24;
    localparam int CRC_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int ROUND_HALF   = 16384;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_PREAMBLE = 2'd1,
        CMD_PAYLOAD  = 2'd2,
        CMD_CHECKSUM = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONE0_STEP     = 3'd0,
        CFG_TONE1_STEP     = 3'd1,
        CFG_CHIRP_LOW_STEP = 3'd2,
        CFG_CHIRP_SLOPE    = 3'd3,
        CFG_CRC_POLY       = 3'd4,
        CFG_DATA_GAIN      = 3'd5,
        CFG_PREAMBLE_GAIN  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_cmd cmd;
        logic data_bit;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_run;
        logic                       frame_done;
    } t_out_word;

    typedef struct packed {
        logic [STEP_W-1:0]  tone0_step;
        logic [STEP_W-1:0]  tone1_step;
        logic [STEP_W-1:0]  chirp_low_step;
        logic [SLOPE_W-1:0] chirp_slope;
        logic [CRC_W-1:0]   crc_poly;
        logic [GAIN_W-1:0]  data_gain;
        logic [GAIN_W-1:0]  preamble_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        tone0_step:     32'd194783097,
        tone1_step:     32'd389566194,
        chirp_low_step: 32'd97391549,
        chirp_slope:    24'd1770755,
        crc_poly:       8'd215,
        data_gain:      15'd29490,
        preamble_gain:  15'd14745
    };

    typedef enum logic [1:0] {
        JOB_CLEAR = 2'd0,
        JOB_CHIRP = 2'd1,
        JOB_TONE  = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind kind;
        logic      tone_bit;
        logic      frame_done;
    } t_job;

    typedef logic [QUARTER:0][MAG_W-1:0] t_sine_qtab;

    // Quarter-wave sine, 32767 * sin(pi/2 * r / QUARTER), by a Q30 Taylor series.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        x    = (64'd1686629713 * 64'(r)) / 64'(QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + longint'(term);
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        return v[MAG_W-1:0];
    endfunction

    function automatic t_sine_qtab build_qtab();
        t_sine_qtab tab;
        int         r;
        for (r = 0; r <= QUARTER; r++) begin
            tab[r] = quarter_sine(r);
        end
        return tab;
    endfunction

    localparam t_sine_qtab SINE_QTAB = build_qtab();

endpackage

// ----- rtl/core/fskc_queue.sv -----
module fskc_queue
    import fskc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/fskc_front.sv -----
module fskc_front
    import fskc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_word         i_in_word,
    input  logic [CRC_W-1:0] i_crc_poly,
    input  logic             i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output t_job             o_job
);

    logic [CRC_W-1:0] r_crc;
    logic [3:0]       r_bits_sent;
    logic [CRC_W-1:0] n_crc;
    logic [3:0]       n_bits_sent;
    logic [CRC_W-1:0] crc_upd;
    logic             accept;
    logic             crc_left;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign crc_left   = !r_bits_sent[3];

    always_comb begin
        crc_upd = r_crc ^ {i_in_word.data_bit, 7'd0};
        for (int i = 0; i < 8; i++) begin
            crc_upd = crc_upd[7] ? ({crc_upd[6:0], 1'b0} ^ i_crc_poly)
                                 : {crc_upd[6:0], 1'b0};
        end
    end

    always_comb begin
        n_crc       = r_crc;
        n_bits_sent = r_bits_sent;
        o_push      = 1'b0;
        o_job       = '{kind: JOB_CLEAR, tone_bit: 1'b0, frame_done: 1'b0};
        if (accept) begin
            unique case (i_in_word.cmd)
                CMD_START: begin
                    n_crc       = '0;
                    n_bits_sent = '0;
                    o_push      = 1'b1;
                end
                CMD_PREAMBLE: begin
                    o_push     = 1'b1;
                    o_job.kind = JOB_CHIRP;
                end
                CMD_PAYLOAD: begin
                    n_crc          = crc_upd;
                    o_push         = 1'b1;
                    o_job.kind     = JOB_TONE;
                    o_job.tone_bit = i_in_word.data_bit;
                end
                CMD_CHECKSUM: begin
                    if (crc_left) begin
                        n_bits_sent      = r_bits_sent + 1'b1;
                        o_push           = 1'b1;
                        o_job.kind       = JOB_TONE;
                        o_job.tone_bit   = r_crc[3'd7 - r_bits_sent[2:0]];
                        o_job.frame_done = (r_bits_sent == 4'd7);
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_bits_sent <= '0;
        end else begin
            r_crc       <= n_crc;
            r_bits_sent <= n_bits_sent;
        end
    end

endmodule

// ----- rtl/core/fskc_back.sv -----
module fskc_back
    import fskc_pkg::*;
#(
    parameter int SAMPLES_PER_BIT  = 44,
    parameter int PREAMBLE_SAMPLES = 440
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_job      i_q_head,
    input  logic      i_q_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CNT_W   = $clog2(SAMPLES_PER_BIT);
    localparam int POS_W   = $clog2(PREAMBLE_SAMPLES);
    localparam int HALF    = PREAMBLE_SAMPLES / 2;
    localparam int DIST_W  = $clog2(HALF + 1);
    localparam int PROD_W  = DIST_W + SLOPE_W;
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SAMPLES_PER_BIT - 1);
    localparam logic [POS_W:0]   POS_TOTAL  = (POS_W + 1)'(PREAMBLE_SAMPLES);
    localparam logic [POS_W-1:0] POS_HALF   = POS_W'(HALF);
    localparam logic [QUARTER_BITS:0] Q_FULL = (QUARTER_BITS + 1)'(QUARTER);

    logic adv;

    // Sequencer: current job and sample counter.
    logic             r_job_valid;
    t_job             r_job;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_pos;
    logic             n_job_valid;
    t_job             n_job;
    logic [CNT_W-1:0] n_cnt;
    logic [POS_W-1:0] n_pos;
    logic             job_end;
    logic             job_clear;
    logic             job_chirp;
    logic             job_tone;
    logic [POS_W:0]   dist_wide;
    logic [DIST_W-1:0] chirp_dist;
    logic [POS_W:0]   pos_inc;
    logic [PROD_W-1:0] chirp_prod;

    // Issue stage.
    logic              r_a_valid;
    logic              r_a_clear;
    logic              r_a_chirp;
    logic              r_a_bit;
    logic              r_a_last;
    logic              r_a_done;
    logic [STEP_W-1:0] r_a_prod;

    // Phase stage.
    logic [STEP_W-1:0]    r_phase;
    logic [STEP_W-1:0]    n_phase;
    logic [STEP_W-1:0]    phase_chirp;
    logic [STEP_W-1:0]    tone_step;
    logic                 r_b_valid;
    logic                 r_b_chirp;
    logic                 r_b_last;
    logic                 r_b_done;
    logic [SINE_BITS-1:0] r_b_idx;

    // Table stage.
    logic [1:0]                 quad;
    logic [QUARTER_BITS:0]      qidx;
    logic [SAMPLE_W-1:0]        sine_pos;
    logic                       r_c_valid;
    logic                       r_c_chirp;
    logic                       r_c_last;
    logic                       r_c_done;
    logic signed [SAMPLE_W-1:0] r_c_sine;

    // Gain and output register.
    logic [GAIN_W-1:0]  gain;
    logic signed [31:0] scaled;
    logic signed [31:0] rounded;
    logic               r_out_valid;
    t_out_word          r_out_word;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign job_clear = r_job_valid && (r_job.kind == JOB_CLEAR);
    assign job_chirp = r_job_valid && (r_job.kind == JOB_CHIRP);
    assign job_tone  = r_job_valid && (r_job.kind == JOB_TONE);
    assign job_end   = r_job_valid && (!(job_chirp || job_tone) || (r_cnt == CNT_LAST));
    assign o_pop     = adv && (!r_job_valid || job_end) && !i_q_empty;

    assign dist_wide  = (r_pos < POS_HALF) ? {1'b0, r_pos} : (POS_TOTAL - {1'b0, r_pos});
    assign chirp_dist = dist_wide[DIST_W-1:0];
    assign pos_inc    = {1'b0, r_pos} + 1'b1;
    assign chirp_prod = PROD_W'(chirp_dist) * PROD_W'(i_cfg.chirp_slope);

    always_comb begin
        n_job_valid = r_job_valid;
        n_job       = r_job;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        if (job_clear) begin
            n_pos = '0;
        end else if (job_chirp) begin
            n_pos = (pos_inc >= POS_TOTAL) ? '0 : pos_inc[POS_W-1:0];
        end
        if (job_end || !r_job_valid) begin
            n_cnt       = '0;
            n_job_valid = !i_q_empty;
            n_job       = i_q_head;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign tone_step   = r_a_bit ? i_cfg.tone1_step : i_cfg.tone0_step;
    assign phase_chirp = r_phase + i_cfg.chirp_low_step + r_a_prod;

    always_comb begin
        n_phase = r_phase;
        if (r_a_clear) begin
            n_phase = '0;
        end else if (r_a_valid) begin
            n_phase = r_a_chirp ? phase_chirp : (r_phase + tone_step);
        end
    end

    assign quad     = r_b_idx[SINE_BITS-1 -: 2];
    assign qidx     = quad[0] ? (Q_FULL - {1'b0, r_b_idx[QUARTER_BITS-1:0]})
                              : {1'b0, r_b_idx[QUARTER_BITS-1:0]};
    assign sine_pos = {1'b0, SINE_QTAB[qidx]};

    assign gain    = r_c_chirp ? i_cfg.preamble_gain : i_cfg.data_gain;
    assign scaled  = r_c_sine * $signed({1'b0, gain});
    assign rounded = scaled + 32'sd16384;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_a_valid   <= 1'b0;
            r_a_clear   <= 1'b0;
            r_phase     <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_job_valid <= n_job_valid;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_a_valid   <= job_chirp || job_tone;
            r_a_clear   <= job_clear;
            r_phase     <= n_phase;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_job                  <= n_job;
            r_a_chirp              <= job_chirp;
            r_a_bit                <= r_job.tone_bit;
            r_a_last               <= (r_cnt == CNT_LAST);
            r_a_done               <= r_job.frame_done && (r_cnt == CNT_LAST);
            r_a_prod               <= STEP_W'(chirp_prod);
            r_b_chirp              <= r_a_chirp;
            r_b_last               <= r_a_last;
            r_b_done               <= r_a_done;
            r_b_idx                <= r_a_chirp ? phase_chirp[STEP_W-1 -: SINE_BITS]
                                                : r_phase[STEP_W-1 -: SINE_BITS];
            r_c_chirp              <= r_b_chirp;
            r_c_last               <= r_b_last;
            r_c_done               <= r_b_done;
            r_c_sine               <= quad[1] ? $signed(16'd0 - sine_pos) : $signed(sine_pos);
            r_out_word.sample      <= rounded[30:15];
            r_out_word.last_of_run <= r_c_last;
            r_out_word.frame_done  <= r_c_done;
        end
    end

endmodule

// ----- rtl/core/fsk_modulator_with_chirp_and_crc8_unit.sv -----
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_in_word  (cmd, data_bit)
// out      | output    | o_out_valid / i_out_stall  | o_out_word (sample, last_of_run,
//          |           |                            |             frame_done)
// cfg      | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// The sample sequencer emits one sample per clock unless stalled; a preamble, payload or checksum
// word gives SAMPLES_PER_BIT samples, a start word or a surplus checksum word none. The front takes
// a new word in any cycle while the job queue (QUEUE_DEPTH words) has room; o_in_stall is
// high while it is full. A dequeued job's first sample passes the issue, phase and table stages
// to the output register. Synchronous active-low reset clears control state (not data) at once;
// no clearing pass follows. High i_out_stall freezes the sample pipeline while o_out_valid is high.
module fsk_modulator_with_chirp_and_crc8_unit
    import fskc_pkg::*;
#(
    parameter int SAMPLES_PER_BIT  = 44,
    parameter int PREAMBLE_SAMPLES = 440,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic push;
    t_job push_job;
    logic pop;
    t_job q_head;
    logic q_full;
    logic q_empty;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TONE0_STEP:     n_cfg.tone0_step     = i_cfg_data;
                CFG_TONE1_STEP:     n_cfg.tone1_step     = i_cfg_data;
                CFG_CHIRP_LOW_STEP: n_cfg.chirp_low_step = i_cfg_data;
                CFG_CHIRP_SLOPE:    n_cfg.chirp_slope    = i_cfg_data[SLOPE_W-1:0];
                CFG_CRC_POLY:       n_cfg.crc_poly       = i_cfg_data[CRC_W-1:0];
                CFG_DATA_GAIN:      n_cfg.data_gain      = i_cfg_data[GAIN_W-1:0];
                CFG_PREAMBLE_GAIN:  n_cfg.preamble_gain  = i_cfg_data[GAIN_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fskc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_crc_poly (r_cfg.crc_poly),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (push_job)
    );

    fskc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fskc_back #(
        .SAMPLES_PER_BIT  (SAMPLES_PER_BIT),
        .PREAMBLE_SAMPLES (PREAMBLE_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- rtl/core/fskc_checker.sv -----
`include "assert_macros.svh"

module fskc_checker
    import fskc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // A stalled word holds until it is taken.
    `CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled output word changed")

    // The samples of one run leave back to back, so a taken word that is not the last has a successor.
    `CHK_NEXT(a_run_gapless, o_out_valid && !i_out_stall && !o_out_word.last_of_run, o_out_valid, "gap inside a sample run")

    `CHK_IMPLY(a_done_is_last, o_out_valid && o_out_word.frame_done, o_out_word.last_of_run, "frame_done on a word that does not end its run")

    `CHK_IMPLY(a_reset_out_idle, $past(!i_rst_n), !o_out_valid, "output valid right after reset")

    `CHK_IMPLY(a_reset_in_open, $past(!i_rst_n), !o_in_stall, "input stalled right after reset")

endmodule

bind fsk_modulator_with_chirp_and_crc8_unit fskc_checker u_fskc_checker (.*);

// ----- verif/fsk_modulator_with_chirp_and_crc8_unit_tb.sv -----
module fsk_modulator_with_chirp_and_crc8_unit_tb;
    import fskc_pkg::*;

    localparam int SPB          = 44;
    localparam int PRE          = 440;
    localparam int TABLE_SIZE   = 1 << SINE_BITS;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FRAME_PCT    = 85;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    fsk_modulator_with_chirp_and_crc8_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_word    pending_words[$];
    t_out_word   expected_samples[$];
    int unsigned send_idle_pct  = 0;
    int unsigned out_idle_pct   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    t_cfg                cfg_model = CFG_RESET;
    logic [31:0]         cur_phase = '0;
    logic [8:0]          chirp_idx = '0;
    logic [7:0]          crc       = '0;
    logic [3:0]          crc_sent  = '0;
    logic signed [15:0]  sine_lut [0:TABLE_SIZE-1];

    // Full-cycle sine table built from a Q30 Taylor series of the quarter wave.
    initial begin
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        int          quarter_mag [0:QUARTER];
        int          r;
        int          n;
        int          k;
        int          q;
        int          mag;
        for (r = 0; r <= QUARTER; r++) begin
            x    = (64'd1686629713 * 64'(r)) / 64'(QUARTER);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            quarter_mag[r] = int'(v);
        end
        for (k = 0; k < TABLE_SIZE; k++) begin
            q   = k / QUARTER;
            r   = k % QUARTER;
            mag = (q % 2 == 1) ? quarter_mag[QUARTER - r] : quarter_mag[r];
            sine_lut[k] = 16'((q / 2 == 1) ? -mag : mag);
        end
    end

    function automatic logic signed [15:0] scaled_sine(logic [GAIN_W-1:0] gain);
        longint p;
        p = longint'(sine_lut[cur_phase[31 -: SINE_BITS]]) * longint'({1'b0, gain})
            + 64'sd16384;
        return 16'(p >>> 15);
    endfunction

    function automatic void push_tone(logic tone_bit, logic done);
        logic [31:0] step;
        t_out_word   s;
        int          k;
        step = tone_bit ? cfg_model.tone1_step : cfg_model.tone0_step;
        for (k = 0; k < SPB; k++) begin
            s.sample      = scaled_sine(cfg_model.data_gain);
            s.last_of_run = (k == SPB - 1);
            s.frame_done  = (k == SPB - 1) && done;
            expected_samples = {expected_samples, s};
            cur_phase = cur_phase + step;
        end
    endfunction

    function automatic void predict_samples(t_in_word w);
        t_out_word   s;
        logic [31:0] chirp_dist;
        logic        tone_bit;
        int          k;
        case (w.cmd)
            CMD_START: begin
                cur_phase = '0;
                chirp_idx = '0;
                crc       = '0;
                crc_sent  = '0;
            end
            CMD_PREAMBLE: begin
                for (k = 0; k < SPB; k++) begin
                    if (chirp_idx >= PRE) begin
                        chirp_idx = '0;
                    end
                    chirp_dist = (chirp_idx < PRE / 2) ? 32'(chirp_idx)
                                                       : 32'(PRE - chirp_idx);
                    cur_phase = cur_phase + cfg_model.chirp_low_step
                                + chirp_dist * 32'(cfg_model.chirp_slope);
                    s.sample      = scaled_sine(cfg_model.preamble_gain);
                    s.last_of_run = (k == SPB - 1);
                    s.frame_done  = 1'b0;
                    expected_samples = {expected_samples, s};
                    chirp_idx = chirp_idx + 9'd1;
                    if (chirp_idx >= PRE) begin
                        chirp_idx = '0;
                    end
                end
            end
            CMD_PAYLOAD: begin
                crc = crc ^ {w.data_bit, 7'b0};
                for (k = 0; k < 8; k++) begin
                    crc = crc[7] ? ({crc[6:0], 1'b0} ^ cfg_model.crc_poly)
                                 : {crc[6:0], 1'b0};
                end
                push_tone(w.data_bit, 1'b0);
            end
            CMD_CHECKSUM: begin
                if (crc_sent < 8) begin
                    tone_bit = crc[3'(7 - crc_sent)];
                    crc_sent = crc_sent + 4'd1;
                    push_tone(tone_bit, crc_sent == 8);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_samples(i_in_word);
                pending_words.delete(0);
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        got = o_out_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected word sample=%0d last=%0b done=%0b",
                                          got.sample, got.last_of_run, got.frame_done));
            end else begin
                want = expected_samples.pop_front();
                if (got.sample !== want.sample || got.last_of_run !== want.last_of_run
                        || got.frame_done !== want.frame_done) begin
                    report_mismatch($sformatf(
                        "sample %0d/%0d last %0b/%0b done %0b/%0b (got/expected)",
                        got.sample, want.sample, got.last_of_run, want.last_of_run,
                        got.frame_done, want.frame_done));
                end
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_samples.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_in_word make_word(t_cmd c);
        t_in_word w;
        w.cmd      = c;
        w.data_bit = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.tone0_step     = $urandom;
        c.tone1_step     = $urandom;
        c.chirp_low_step = $urandom;
        c.chirp_slope    = SLOPE_W'($urandom);
        c.crc_poly       = CRC_W'($urandom);
        c.data_gain      = GAIN_W'($urandom);
        c.preamble_gain  = GAIN_W'($urandom);
        return c;
    endfunction

    task automatic load_config(t_cfg c);
        t_cfg_idx idx;
        int       i;
        for (i = 0; i <= int'(CFG_PREAMBLE_GAIN); i++) begin
            idx = t_cfg_idx'(i);
            @(posedge i_clk);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            case (idx)
                CFG_TONE0_STEP:     i_cfg_data <= c.tone0_step;
                CFG_TONE1_STEP:     i_cfg_data <= c.tone1_step;
                CFG_CHIRP_LOW_STEP: i_cfg_data <= c.chirp_low_step;
                CFG_CHIRP_SLOPE:    i_cfg_data <= 32'(c.chirp_slope);
                CFG_CRC_POLY:       i_cfg_data <= 32'(c.crc_poly);
                CFG_DATA_GAIN:      i_cfg_data <= 32'(c.data_gain);
                CFG_PREAMBLE_GAIN:  i_cfg_data <= 32'(c.preamble_gain);
                default:            i_cfg_data <= '0;
            endcase
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
        end
        cfg_model = c;
    endtask

    task automatic queue_random_frames(int unsigned target);
        int unsigned counted;
        int unsigned n;
        int unsigned k;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(0, 99) < FRAME_PCT) begin
                pending_words = {pending_words, make_word(CMD_START)};
                n = $urandom_range(0, 11);
                for (k = 0; k < n; k++) begin
                    pending_words = {pending_words, make_word(CMD_PREAMBLE)};
                end
                counted += n + 1;
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    pending_words = {pending_words, make_word(CMD_PAYLOAD)};
                end
                counted += n;
                for (k = 0; k < 8; k++) begin
                    pending_words = {pending_words, make_word(CMD_CHECKSUM)};
                end
                counted += 8;
                if ($urandom_range(0, 3) == 0) begin
                    pending_words = {pending_words, make_word(CMD_CHECKSUM)};
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    pending_words = {pending_words, make_word(t_cmd'($urandom_range(0, 3)))};
                end
                counted += n;
            end
        end
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || expected_samples.size() != 0) begin
            @(negedge i_clk);
        end
        out_idle_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in_word w;
        int       k;
        repeat (2) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct <= 38;
        out_idle_pct  <= 64;

        // Directed: a full chirp plus a restart, payload, the checksum, an
        // ignored extra checksum word, and a payload bit after the checksum.
        @(negedge i_clk);
        w = '{cmd: CMD_START, data_bit: 1'b1};
        pending_words = {pending_words, w};
        for (k = 0; k < 11; k++) begin
            w = '{cmd: CMD_PREAMBLE, data_bit: 1'(k % 2)};
            pending_words = {pending_words, w};
        end
        w = '{cmd: CMD_PAYLOAD, data_bit: 1'b1};
        pending_words = {pending_words, w};
        w = '{cmd: CMD_PAYLOAD, data_bit: 1'b0};
        pending_words = {pending_words, w};
        for (k = 0; k < 9; k++) begin
            w = '{cmd: CMD_CHECKSUM, data_bit: 1'(k % 2)};
            pending_words = {pending_words, w};
        end
        w = '{cmd: CMD_PAYLOAD, data_bit: 1'b1};
        pending_words = {pending_words, w};
        w = '{cmd: CMD_CHECKSUM, data_bit: 1'b0};
        pending_words = {pending_words, w};
        settle();

        load_config('1);
        send_idle_pct <= 38;
        out_idle_pct  <= 64;
        @(negedge i_clk);
        queue_random_frames(22);
        settle();

        load_config('0);
        send_idle_pct <= 64;
        out_idle_pct  <= 38;
        @(negedge i_clk);
        queue_random_frames(22);
        settle();

        load_config(random_config());
        send_idle_pct <= 64;
        out_idle_pct  <= 38;
        @(negedge i_clk);
        queue_random_frames(22);
        settle();

        load_config(random_config());
        send_idle_pct <= 0;
        out_idle_pct  <= 0;
        @(negedge i_clk);
        queue_random_frames(22);
        settle();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fskc_pkg.sv
rtl/core/fskc_queue.sv
rtl/core/fskc_front.sv
rtl/core/fskc_back.sv
rtl/core/fsk_modulator_with_chirp_and_crc8_unit.sv
rtl/core/fskc_checker.sv
verif/fsk_modulator_with_chirp_and_crc8_unit_tb.sv
